@@ hdl/sha_pkg.sv @@
// Shared types, constants and round tables for the streaming SHA-512 hasher.
// No dependencies.
package sha_pkg;

    localparam int unsigned WordW   = 64;
    localparam int unsigned BlkBytes = 128;
    localparam int unsigned Rounds  = 80;

    localparam logic [7:0] PadByte   = 8'h80;
    localparam logic [6:0] LenOffset = 7'd112;

    typedef logic [63:0] t_word;

    typedef struct packed {
        t_word      data;
        logic [3:0] cnt;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_PAD,
        S_PAD2,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    localparam t_word Iv [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam t_word RoundK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word ror64(input t_word x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ hdl/sha_if.sv @@
// Stream interfaces for message words and digest words.
// No dependencies.
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        final_word;
    modport source (output valid, data_word, valid_bytes, final_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, final_word, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

@@ hdl/sha_front.sv @@
// Front end: accepts message words, clamps the byte count, queues requests.
// Depends on sha_pkg and sha_if.
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha_in_if.sink        i_msg,
    input  logic          i_pop,
    output logic          o_q_vld,
    output sha_pkg::t_item o_q_item
);
    import sha_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.data = i_msg.data_word;
        w_item.cnt  = (i_msg.valid_bytes > 4'd8) ? 4'd8 : i_msg.valid_bytes;
        w_item.last = i_msg.final_word;
    end

    assign i_msg.ready = (r_cnt != 2'd2);
    assign w_push      = i_msg.valid && i_msg.ready;
    assign o_q_vld     = (r_cnt != 2'd0);
    assign o_q_item    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

@@ hdl/sha_core.sv @@
// Back end: block packing, padding, 80-round compression, digest output.
// Depends on sha_pkg and sha_if.
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_vld,
    input  sha_pkg::t_item i_q_item,
    output logic           o_pop,
    sha_out_if.source      o_dig
);
    import sha_pkg::*;

    t_state r_state, n_state, r_ret;
    t_word  r_chain [8];
    t_word  r_v [8];
    t_word  r_win [16];
    logic [1023:0] r_blk, n_blk;
    logic [6:0]  r_fill;
    logic [63:0] r_len;
    logic [63:0] r_pw;
    logic [3:0]  r_pc;
    logic        r_last;
    logic [6:0]  r_rnd;
    logic [2:0]  r_idx;

    logic [7:0]  w_room, w_n, w_sum;
    logic [6:0]  w_off;
    t_word       w_wnew, w_t1, w_t2, w_a2, w_a15;
    logic        w_out_acc;

    assign w_room = 8'd128 - {1'b0, r_fill};
    assign w_n    = ({4'd0, r_pc} > w_room) ? w_room : {4'd0, r_pc};
    assign w_sum  = {1'b0, r_fill} + w_n;
    assign w_out_acc = o_dig.valid && o_dig.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q_vld) n_state = S_APPEND;
            S_APPEND: begin
                if (w_sum == 8'd128) n_state = S_ROUND;
                else n_state = r_last ? S_PAD : S_IDLE;
            end
            S_PAD:    n_state = S_ROUND;
            S_PAD2:   n_state = S_ROUND;
            S_ROUND:  if (r_rnd == 7'(Rounds - 1)) n_state = S_FOLD;
            S_FOLD:   n_state = r_ret;
            S_OUT:    if (w_out_acc && r_idx == 3'd7) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop             = (r_state == S_IDLE) && i_q_vld;
        o_dig.valid       = (r_state == S_OUT);
        o_dig.digest_word = r_chain[r_idx];
        o_dig.word_index  = r_idx;
        o_dig.digest_done = (r_idx == 3'd7);
    end

    // block buffer update
    always_comb begin
        n_blk = r_blk;
        for (int k = 0; k < BlkBytes; k++) begin
            w_off = 7'(k) - r_fill;
            case (r_state)
                S_APPEND: if ({1'b0, w_off} < w_n)
                    n_blk[1023 - 8*k -: 8] = r_pw[(7 - w_off[2:0])*8 +: 8];
                S_PAD: begin
                    if (7'(k) == r_fill) n_blk[1023 - 8*k -: 8] = PadByte;
                    else if (7'(k) > r_fill) n_blk[1023 - 8*k -: 8] = 8'd0;
                end
                S_PAD2:  n_blk[1023 - 8*k -: 8] = 8'd0;
                default: ;
            endcase
        end
        if ((r_state == S_PAD && r_fill < LenOffset) || r_state == S_PAD2)
            n_blk[63:0] = r_len;
        w_off = 7'd0;
    end

    // round datapath
    always_comb begin
        w_a2  = r_win[14];
        w_a15 = r_win[1];
        w_wnew = (ror64(w_a2, 19) ^ ror64(w_a2, 61) ^ (w_a2 >> 6)) + r_win[9]
               + (ror64(w_a15, 1) ^ ror64(w_a15, 8) ^ (w_a15 >> 7)) + r_win[0];
        w_t1 = r_v[7] + (ror64(r_v[4], 14) ^ ror64(r_v[4], 18) ^ ror64(r_v[4], 41))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RoundK[r_rnd] + r_win[0];
        w_t2 = (ror64(r_v[0], 28) ^ ror64(r_v[0], 34) ^ ror64(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (n_state == S_ROUND && r_state != S_ROUND) begin
            for (int i = 0; i < 16; i++) r_win[i] <= n_blk[1023 - 64*i -: 64];
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
        end else if (r_state == S_ROUND) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= w_wnew;
            for (int i = 1; i < 8; i++) r_v[i] <= (i == 4) ? r_v[3] + w_t1 : r_v[i-1];
            r_v[0] <= w_t1 + w_t2;
        end
        if (r_state == S_IDLE && i_q_vld) begin
            r_pw   <= i_q_item.data;
            r_pc   <= i_q_item.cnt;
            r_last <= i_q_item.last;
        end else if (r_state == S_APPEND) begin
            r_pw <= r_pw << {w_n[3:0], 3'd0};
            r_pc <= r_pc - w_n[3:0];
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= 7'd0;
            r_len   <= 64'd0;
            r_rnd   <= 7'd0;
            r_idx   <= 3'd0;
            for (int i = 0; i < 8; i++) r_chain[i] <= Iv[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_q_vld) r_len <= r_len + {57'd0, i_q_item.cnt, 3'd0};
                S_APPEND: begin
                    r_fill <= w_sum[6:0];
                    r_ret  <= S_APPEND;
                end
                S_PAD: begin
                    r_fill <= 7'd0;
                    r_ret  <= (r_fill < LenOffset) ? S_OUT : S_PAD2;
                end
                S_PAD2:  r_ret <= S_OUT;
                S_ROUND: r_rnd <= (r_rnd == 7'(Rounds - 1)) ? 7'd0 : r_rnd + 7'd1;
                S_FOLD:  for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                S_OUT: if (w_out_acc) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        for (int i = 0; i < 8; i++) r_chain[i] <= Iv[i];
                        r_len <= 64'd0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/sha512_stream_hasher.sv @@
// Top level of the streaming SHA-512 hasher.
// Depends on sha_pkg, sha_if, sha_front and sha_core.
//
// Usage:
//   i_msg carries message words, big-endian, with a count of leading valid
//   bytes (counts above eight act as eight) and a flag on the final word.
//   o_dig returns the digest as eight requests, word_index 0..7, with
//   digest_done on the last; the hasher then restarts from the initial
//   hash values for the next message.
// Timing:
//   A two-entry queue decouples input from the hashing engine, so words
//   are taken while the engine compresses or a digest waits.
//   Each word is packed into the block buffer in the IDLE and APPEND states;
//   each full 128-byte block then takes the rounds (one round per cycle),
//   the fold into the chaining value and one more packing pass.
//   A final word adds, per padded block (one or two blocks), a padding state
//   (PAD, then PAD2) and a compression (rounds and fold); the digest words
//   then follow one per cycle while o_dig.ready is high.
// Reset and stall:
//   Synchronous active-low reset empties the queue, clears fill and
//   length and loads the initial hash values. A stalled receiver holds
//   the current digest word; the queue then fills and i_msg.ready drops.
module sha512_stream_hasher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha_in_if.sink    i_msg,
    sha_out_if.source o_dig
);
    import sha_pkg::*;

    logic  w_pop, w_q_vld;
    t_item w_q_item;

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (i_msg),
        .i_pop   (w_pop),
        .o_q_vld (w_q_vld),
        .o_q_item(w_q_item)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_vld (w_q_vld),
        .i_q_item(w_q_item),
        .o_pop   (w_pop),
        .o_dig   (o_dig)
    );

endmodule

@@ hdl/sha_chk.sv @@
// Port-level checks for the SHA-512 hasher, bound to the top level.
// Depends on sha512_stream_hasher.
module sha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_ov,
    input logic        i_or,
    input logic [63:0] i_word,
    input logic [2:0]  i_idx,
    input logic        i_done
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ov && !i_or |=> i_ov && $stable(i_word) && $stable(i_idx))
        else $error("digest word changed under stall");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ov |-> (i_done == (i_idx == 3'd7)))
        else $error("done flag not on last word");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ov && i_or && !i_done |=> i_ov && i_idx == $past(i_idx) + 3'd1)
        else $error("digest burst broken");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_ov)
        else $error("digest valid after reset");
endmodule

bind sha512_stream_hasher sha_chk u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_ov   (o_dig.valid),
    .i_or   (o_dig.ready),
    .i_word (o_dig.digest_word),
    .i_idx  (o_dig.word_index),
    .i_done (o_dig.digest_done)
);
